[design/hsv2rgb_pkg.sv]
// Constants, sector codes and the divide-by-255 helper for the HSV to RGB converter.
`default_nettype none
package hsv2rgb_pkg;

    localparam int unsigned FULL_SCALE = 255;
    // 255 * 65536: unit value in the fraction-scaled products
    localparam logic [23:0] TOP_SCALE  = 24'hFF0000;
    localparam logic [16:0] FRAC_ONE   = 17'h10000;
    // Reciprocal of 255 for a 16-bit dividend, exact with a 23-bit shift
    localparam logic [15:0] RECIP_255  = 16'h8081;

    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;

    typedef logic [7:0] t_chan;

    // floor(x / 255) for x up to 65279, so that the quotient fits in 8 bits
    function automatic t_chan div255(input logic [15:0] x);
        logic [31:0] prod;
        prod = x * RECIP_255;
        return prod[30:23];
    endfunction

endpackage
`default_nettype wire

[design/hsv_to_rgb_converter_unit.sv]
// HSV to 8-bit RGB pixel converter, four-stage pipeline.
// Throughput: one pixel per cycle; each stage holds only while the stage after it is full
// and cannot advance, so bubbles are squeezed out under output stall.
// Reset (synchronous, active low) clears the stage valid bits; data registers are not reset.
`default_nettype none
module hsv_to_rgb_converter_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [15:0]         i_hue,
    input  wire  [7:0]          i_saturation,
    input  wire  [7:0]          i_brightness,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output hsv2rgb_pkg::t_chan  o_red,
    output hsv2rgb_pkg::t_chan  o_green,
    output hsv2rgb_pkg::t_chan  o_blue
);
    import hsv2rgb_pkg::*;

    logic [3:0] r_vld;
    logic [3:0] en;

    // Stage 1: sector/fraction split and a-numerator
    logic [2:0]  r1_sector;
    logic [15:0] r1_frac;
    logic [7:0]  r1_sat;
    logic [7:0]  r1_val;
    logic [15:0] r1_anum;
    // Stage 2: b/c scale factors, a done
    logic [23:0] r2_mb;
    logic [23:0] r2_mc;
    t_chan       r2_a;
    logic [2:0]  r2_sector;
    logic [7:0]  r2_val;
    // Stage 3: scaled b/c before the divide by 255
    logic [15:0] r3_qb;
    logic [15:0] r3_qc;
    t_chan       r3_a;
    logic [2:0]  r3_sector;
    logic [7:0]  r3_val;
    // Stage 4: output
    t_chan       r4_red;
    t_chan       r4_green;
    t_chan       r4_blue;

    logic [18:0] n_h6;
    logic [15:0] n_anum;
    logic [23:0] n_sf;
    logic [24:0] n_snf;
    logic [16:0] n_nf;
    logic [31:0] n_pb;
    logic [31:0] n_pc;
    t_chan       n_b;
    t_chan       n_c;
    t_chan       n_red;
    t_chan       n_green;
    t_chan       n_blue;

    // A stage advances when it is empty or the next one advances
    assign en[3] = !r_vld[3] || !i_out_stall;
    assign en[2] = !r_vld[2] || en[3];
    assign en[1] = !r_vld[1] || en[2];
    assign en[0] = !r_vld[0] || en[1];

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_vld[3];
    assign o_red       = r4_red;
    assign o_green     = r4_green;
    assign o_blue      = r4_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_in_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_comb begin
        n_h6   = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};
        n_anum = i_brightness * (8'(FULL_SCALE) - i_saturation);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_sector <= n_h6[18:16];
            r1_frac   <= n_h6[15:0];
            r1_sat    <= i_saturation;
            r1_val    <= i_brightness;
            r1_anum   <= n_anum;
        end
    end

    always_comb begin
        n_sf  = r1_sat * r1_frac;
        n_nf  = FRAC_ONE - {1'b0, r1_frac};
        n_snf = r1_sat * n_nf;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_mb     <= TOP_SCALE - n_sf;
            r2_mc     <= TOP_SCALE - n_snf[23:0];
            r2_a      <= div255(r1_anum);
            r2_sector <= r1_sector;
            r2_val    <= r1_val;
        end
    end

    always_comb begin
        n_pb = r2_val * r2_mb;
        n_pc = r2_val * r2_mc;
    end

    // Drop the low 16 bits first; the remaining divide by 255 is exact on the quotient
    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_qb     <= n_pb[31:16];
            r3_qc     <= n_pc[31:16];
            r3_a      <= r2_a;
            r3_sector <= r2_sector;
            r3_val    <= r2_val;
        end
    end

    always_comb begin
        n_b = div255(r3_qb);
        n_c = div255(r3_qc);
        case (r3_sector)
            SECT_0: begin
                n_red = r3_val; n_green = n_c;    n_blue = r3_a;
            end
            SECT_1: begin
                n_red = n_b;    n_green = r3_val; n_blue = r3_a;
            end
            SECT_2: begin
                n_red = r3_a;   n_green = r3_val; n_blue = n_c;
            end
            SECT_3: begin
                n_red = r3_a;   n_green = n_b;    n_blue = r3_val;
            end
            SECT_4: begin
                n_red = n_c;    n_green = r3_a;   n_blue = r3_val;
            end
            default: begin
                n_red = r3_val; n_green = r3_a;   n_blue = n_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_red   <= n_red;
            r4_green <= n_green;
            r4_blue  <= n_blue;
        end
    end

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the HSV to RGB pixel converter with random flow control.
`timescale 1ns / 100ps
module tb;
    import hsv2rgb_pkg::*;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    localparam int STUCK_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES    = 12;
    localparam int PRINT_LIMIT     = 200;

    // First hue of each sector
    localparam logic [15:0] SECTOR_EDGES [6] = '{16'd0, 16'd10923, 16'd21846,
                                                  16'd32768, 16'd43691, 16'd54614};

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [15:0] i_hue        = '0;
    logic [7:0]  i_saturation = '0;
    logic [7:0]  i_brightness = '0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_chan       o_red;
    t_chan       o_green;
    t_chan       o_blue;

    t_idle_mode  idle_mode    = IDLE_NONE;
    logic        hold_request = 1'b0;
    int          hold_left    = 0;
    int          stuck_cycles = 0;

    hsv_to_rgb_converter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_rgb hsv_pixel_to_rgb(input logic [15:0] hue, input logic [7:0] sat,
                                              input logic [7:0] bri);
        logic [18:0] hue6;
        logic [2:0]  sector;
        logic [15:0] frac;
        logic [63:0] full_turn;
        t_chan       a_ch;
        t_chan       b_ch;
        t_chan       c_ch;
        t_rgb        px;
        hue6      = 19'(hue) * 19'd6;
        sector    = hue6[18:16];
        frac      = hue6[15:0];
        full_turn = 64'(FULL_SCALE) * 64'(FRAC_ONE);
        a_ch = t_chan'((64'(bri) * (64'(FULL_SCALE) - 64'(sat))) / 64'(FULL_SCALE));
        b_ch = t_chan'((64'(bri) * (full_turn - 64'(sat) * 64'(frac))) / full_turn);
        c_ch = t_chan'((64'(bri) * (full_turn - 64'(sat) * (64'(FRAC_ONE) - 64'(frac))))
                       / full_turn);
        case (sector)
            SECT_0:  px = '{bri, c_ch, a_ch};
            SECT_1:  px = '{b_ch, bri, a_ch};
            SECT_2:  px = '{a_ch, bri, c_ch};
            SECT_3:  px = '{a_ch, b_ch, bri};
            SECT_4:  px = '{c_ch, a_ch, bri};
            default: px = '{bri, a_ch, b_ch};
        endcase
        return px;
    endfunction

    class rgb_scoreboard;
        t_rgb pending [$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < PRINT_LIMIT)
                $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function void note_pixel(input logic [15:0] hue, input logic [7:0] sat,
                                 input logic [7:0] bri);
            pending.push_back(hsv_pixel_to_rgb(hue, sat, bri));
        endfunction

        task check_chan(input string name, input t_chan got, input t_chan want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        task check_pixel(input t_chan red, input t_chan green, input t_chan blue);
            t_rgb want;
            if (pending.size() == 0) begin
                report_mismatch("result with no pixel outstanding");
                return;
            end
            want = pending.pop_front();
            check_chan("red", red, want.red);
            check_chan("green", green, want.green);
            check_chan("blue", blue, want.blue);
        endtask
    endclass

    rgb_scoreboard scoreboard;

    function automatic logic idle_roll(input logic sender_side);
        int pct;
        pct = 0;
        case (idle_mode)
            IDLE_SENDER:   pct = sender_side ? 51 : 0;
            IDLE_RECEIVER: pct = sender_side ? 0 : 51;
            IDLE_BOTH:     pct = 18;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
                              input logic [7:0] bri);
        while (idle_roll(1'b1)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bri;
        do @(posedge i_clk); while (o_in_stall);
        scoreboard.note_pixel(hue, sat, bri);
    endtask

    task automatic send_random(input int count);
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  bri;
        for (int n = 0; n < count; n++) begin
            // favor hues near sector edges and full or empty saturation and value
            if ($urandom_range(3) == 0)
                hue = SECTOR_EDGES[$urandom_range(5)] + 16'($urandom_range(6)) - 16'd3;
            else
                hue = 16'($urandom);
            sat = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                           : 8'($urandom);
            bri = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                           : 8'($urandom);
            send_pixel(hue, sat, bri);
        end
    endtask

    // Output side: check each transfer, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            scoreboard.check_pixel(o_red, o_green, o_blue);
        if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_roll(1'b0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        scoreboard = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // black, full red, top of the hue range
        send_pixel(16'd0, 8'd0, 8'd0);
        send_pixel(16'd0, 8'd255, 8'd255);
        send_pixel(16'd65535, 8'd255, 8'd255);
        // both sides of every sector edge
        send_pixel(16'd10922, 8'd255, 8'd255);
        send_pixel(16'd10923, 8'd255, 8'd255);
        send_pixel(16'd21845, 8'd255, 8'd255);
        send_pixel(16'd21846, 8'd255, 8'd255);
        send_pixel(16'd32767, 8'd255, 8'd255);
        send_pixel(16'd32768, 8'd255, 8'd255);
        send_pixel(16'd43690, 8'd255, 8'd255);
        send_pixel(16'd43691, 8'd255, 8'd255);
        send_pixel(16'd54613, 8'd255, 8'd255);
        send_pixel(16'd54614, 8'd255, 8'd255);
        // gray, black at full saturation, mid values
        send_pixel(16'h8000, 8'd0, 8'd255);
        send_pixel(16'h1234, 8'd255, 8'd0);
        send_pixel(16'hFFFF, 8'h80, 8'h7F);
        send_pixel(16'h5555, 8'd1, 8'd254);
        send_pixel(16'hAAAA, 8'd254, 8'd1);
        send_pixel(16'h2AAA, 8'd128, 8'd200);

        // hold the output off while input keeps coming so the pipeline backs up
        hold_request = 1'b1;
        send_random(150);

        idle_mode = IDLE_SENDER;
        send_random(320);
        idle_mode = IDLE_RECEIVER;
        send_random(320);
        idle_mode = IDLE_BOTH;
        send_random(320);
        idle_mode = IDLE_NONE;
        send_random(290);
        i_in_valid <= 1'b0;

        while (scoreboard.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (scoreboard.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[files.f]
design/hsv2rgb_pkg.sv
design/hsv_to_rgb_converter_unit.sv
tb/tb.sv
